### src/pwsf_pkg.sv
package pwsf_pkg;

   // Configuration register widths and reset values
   localparam int TARGET_BITS     = 12;
   localparam int GAP_BITS        = 8;
   localparam int ITER_BITS       = 10;
   localparam int MID_BITS        = 8;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 12;
   localparam int STAGE_BITS      = 3;

   localparam logic [TARGET_BITS-1:0] TARGET_RESET = 12'd2048;
   localparam logic [GAP_BITS-1:0]    GAP_RESET    = 8'd4;
   localparam logic [ITER_BITS-1:0]   ITER_RESET   = 10'd400;
   localparam logic [MID_BITS-1:0]    MID_RESET    = 8'd128;

   // Register indexes on the configuration channel
   localparam logic [CSR_INDEX_BITS-1:0] REG_SENSOR_TARGET  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GAP_TOP_BOT    = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ITER_LIMIT     = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MID_DEFAULT    = 2'd3;

   // Command codes
   localparam logic CMD_START  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // Finder stages
   localparam logic [STAGE_BITS-1:0] ST_IDLE   = 3'd0;
   localparam logic [STAGE_BITS-1:0] ST_SEARCH = 3'd1;
   localparam logic [STAGE_BITS-1:0] ST_SIDE   = 3'd2;
   localparam logic [STAGE_BITS-1:0] ST_TRACK  = 3'd3;
   localparam logic [STAGE_BITS-1:0] ST_DONE   = 3'd4;

   // Drag step limits for the mid wiper
   localparam logic [1:0] DRAG_MIN = 2'd1;
   localparam logic [1:0] DRAG_MAX = 2'd3;

   typedef struct packed {
      logic [TARGET_BITS-1:0] sensor_target;
      logic [GAP_BITS-1:0]    gap_top_bot;
      logic [ITER_BITS-1:0]   iter_limit;
      logic [MID_BITS-1:0]    mid_default;
   } pwsf_cfg_type;

   typedef struct packed {
      logic [STAGE_BITS-1:0] stage;
      logic                  flip_seen;
   } pwsf_status_type;

endpackage

### src/pwsf_if.sv
interface pwsf_req_if #(
   parameter int SAMPLE_BITS = 12
);
   logic                   valid;
   logic                   ready;
   logic                   command;
   logic [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output command, output sample, input ready);
   modport sink   (input valid, input command, input sample, output ready);
endinterface

interface pwsf_rsp_if #(
   parameter int WIPER_BITS = 8
);
   logic                                valid;
   logic                                ready;
   logic [WIPER_BITS-1:0]               top_level;
   logic [WIPER_BITS-1:0]               bottom_level;
   logic [WIPER_BITS-1:0]               mid_level;
   logic [pwsf_pkg::STAGE_BITS-1:0]     stage;
   logic                                found;
   logic                                finished;

   modport source (output valid, output top_level, output bottom_level, output mid_level,
                   output stage, output found, output finished, input ready);
   modport sink   (input valid, input top_level, input bottom_level, input mid_level,
                   input stage, input found, input finished, output ready);
endinterface

interface pwsf_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [pwsf_pkg::CSR_INDEX_BITS-1:0]   index;
   logic [pwsf_pkg::CSR_DATA_BITS-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### src/pwsf_csr.sv
module pwsf_csr (
   input  logic                   clock,
   input  logic                   reset,
   pwsf_csr_if.sink               csr_ch,
   output pwsf_pkg::pwsf_cfg_type cfg
);

   pwsf_pkg::pwsf_cfg_type cfg_ff;
   pwsf_pkg::pwsf_cfg_type cfg_in;

   // Register writes are always taken
   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            pwsf_pkg::REG_SENSOR_TARGET: begin
               cfg_in.sensor_target = csr_ch.data[pwsf_pkg::TARGET_BITS-1:0];
            end
            pwsf_pkg::REG_GAP_TOP_BOT: begin
               cfg_in.gap_top_bot = csr_ch.data[pwsf_pkg::GAP_BITS-1:0];
            end
            pwsf_pkg::REG_ITER_LIMIT: begin
               cfg_in.iter_limit = csr_ch.data[pwsf_pkg::ITER_BITS-1:0];
            end
            pwsf_pkg::REG_MID_DEFAULT: begin
               cfg_in.mid_default = csr_ch.data[pwsf_pkg::MID_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sensor_target  <= pwsf_pkg::TARGET_RESET;
         cfg_ff.gap_top_bot    <= pwsf_pkg::GAP_RESET;
         cfg_ff.iter_limit     <= pwsf_pkg::ITER_RESET;
         cfg_ff.mid_default    <= pwsf_pkg::MID_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### src/pwsf_finder.sv
module pwsf_finder #(
   parameter int WIPER_BITS  = 8,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            take,
   input  logic                            command,
   input  logic [SAMPLE_BITS-1:0]          sample,
   input  pwsf_pkg::pwsf_cfg_type          cfg,
   output logic [WIPER_BITS-1:0]           top_level,
   output logic [WIPER_BITS-1:0]           bottom_level,
   output logic [WIPER_BITS-1:0]           mid_level,
   output logic [pwsf_pkg::STAGE_BITS-1:0] stage,
   output logic                            found,
   output logic                            finished,
   output pwsf_pkg::pwsf_status_type       status
);

   // Compare width wide enough for the wiper range and twice the gap
   localparam int CW = WIPER_BITS + 4;
   localparam int LW = (SAMPLE_BITS > pwsf_pkg::TARGET_BITS) ? SAMPLE_BITS
                                                               : pwsf_pkg::TARGET_BITS;
   localparam logic [WIPER_BITS-1:0] WMAX = {WIPER_BITS{1'b1}};

   logic [pwsf_pkg::STAGE_BITS-1:0] stage_ff, stage_in;
   logic [WIPER_BITS-1:0]           top_ff, top_in;
   logic [WIPER_BITS-1:0]           bot_ff, bot_in;
   logic [WIPER_BITS-1:0]           mid_ff, mid_in;
   logic [WIPER_BITS-1:0]           shi_ff, shi_in;
   logic [WIPER_BITS-1:0]           slo_ff, slo_in;
   logic                            ils_ff, ils_in;
   logic                            flip_ff, flip_in;
   logic [pwsf_pkg::ITER_BITS-1:0]  cnt_ff, cnt_in;

   logic                  low;
   logic [WIPER_BITS-1:0] mid_tgt;
   logic [CW-1:0]         gap_ext;
   logic [CW-1:0]         gap2;
   logic [WIPER_BITS:0]   sum_hi;
   logic [WIPER_BITS:0]   sum_lo;
   logic [WIPER_BITS-1:0] mid_dev;
   logic [WIPER_BITS-1:0] mid_dev_q;
   logic [1:0]            drag;

   // Tracking ends on a narrow enough window or on the iteration limit
   function automatic logic tracking_over(
      input logic [WIPER_BITS-1:0]          t,
      input logic [WIPER_BITS-1:0]          b,
      input logic [pwsf_pkg::ITER_BITS-1:0] n,
      input logic [CW-1:0]                  g,
      input logic [pwsf_pkg::ITER_BITS-1:0] lim
   );
      logic span_ok;
      span_ok = (t <= b) || (CW'(t - b) <= g);
      return span_ok || (n >= lim);
   endfunction

   // Sample side and the clamped mid target
   assign low     = LW'(sample) < LW'(cfg.sensor_target);
   assign mid_tgt = (CW'(cfg.mid_default) > CW'(WMAX)) ? WMAX
                                                        : WIPER_BITS'(cfg.mid_default);
   assign gap_ext = CW'(cfg.gap_top_bot);
   assign gap2    = CW'({cfg.gap_top_bot, 1'b0});

   // Binary search midpoints
   assign sum_hi = {1'b0, mid_ff} + {1'b0, shi_ff};
   assign sum_lo = {1'b0, mid_ff} + {1'b0, slo_ff};

   // Drag step: a quarter of the distance to the target, held between one and three
   assign mid_dev   = (mid_ff > mid_tgt) ? (mid_ff - mid_tgt) : (mid_tgt - mid_ff);
   assign mid_dev_q = mid_dev >> 2;
   assign drag      = (mid_dev_q == '0) ? pwsf_pkg::DRAG_MIN :
                      (mid_dev_q > WIPER_BITS'(pwsf_pkg::DRAG_MAX)) ? pwsf_pkg::DRAG_MAX :
                      mid_dev_q[1:0];

   always_comb begin
      stage_in = stage_ff;
      top_in   = top_ff;
      bot_in   = bot_ff;
      mid_in   = mid_ff;
      shi_in   = shi_ff;
      slo_in   = slo_ff;
      ils_in   = ils_ff;
      flip_in  = flip_ff;
      cnt_in   = cnt_ff;
      if (take) begin
         if (command == pwsf_pkg::CMD_START) begin
            top_in   = WMAX;
            bot_in   = '0;
            mid_in   = mid_tgt;
            shi_in   = WMAX;
            slo_in   = '0;
            ils_in   = 1'b0;
            flip_in  = 1'b0;
            cnt_in   = '0;
            stage_in = (CW'(WMAX) > gap2) ? pwsf_pkg::ST_SEARCH : pwsf_pkg::ST_SIDE;
         end else begin
            case (stage_ff)
               pwsf_pkg::ST_SEARCH: begin
                  if (low) begin
                     slo_in = mid_ff;
                     mid_in = sum_hi[WIPER_BITS:1];
                  end else begin
                     shi_in = mid_ff;
                     mid_in = sum_lo[WIPER_BITS:1];
                  end
                  if ((shi_in <= slo_in) || (CW'(shi_in - slo_in) <= gap2)) begin
                     stage_in = pwsf_pkg::ST_SIDE;
                  end
               end
               pwsf_pkg::ST_SIDE: begin
                  ils_in   = low;
                  stage_in = tracking_over(top_ff, bot_ff, cnt_ff, gap_ext,
                                           cfg.iter_limit) ? pwsf_pkg::ST_DONE
                                                           : pwsf_pkg::ST_TRACK;
               end
               pwsf_pkg::ST_TRACK: begin
                  if (!flip_ff) begin
                     // Walk mid towards the initial side until the side flips
                     if (low == ils_ff) begin
                        if (low) begin
                           mid_in = (mid_ff == WMAX) ? mid_ff : mid_ff + 1'b1;
                        end else begin
                           mid_in = (mid_ff == '0) ? mid_ff : mid_ff - 1'b1;
                        end
                     end else begin
                        flip_in = 1'b1;
                     end
                  end else begin
                     // Close the window by one and drag mid back to its default
                     if (low) begin
                        top_in = (top_ff == '0) ? top_ff : top_ff - 1'b1;
                     end else begin
                        bot_in = (bot_ff == WMAX) ? bot_ff : bot_ff + 1'b1;
                     end
                     if (mid_ff > mid_tgt) begin
                        mid_in = mid_ff - WIPER_BITS'(drag);
                     end else if (mid_ff < mid_tgt) begin
                        mid_in = mid_ff + WIPER_BITS'(drag);
                     end
                  end
                  cnt_in = cnt_ff + 1'b1;
                  if (tracking_over(top_in, bot_in, cnt_in, gap_ext, cfg.iter_limit)) begin
                     stage_in = pwsf_pkg::ST_DONE;
                  end
               end
               default: begin
                  stage_in = stage_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= pwsf_pkg::ST_IDLE;
         top_ff   <= WMAX;
         bot_ff   <= '0;
         mid_ff   <= (CW'(pwsf_pkg::MID_RESET) > CW'(WMAX)) ? WMAX
                                                            : WIPER_BITS'(pwsf_pkg::MID_RESET);
         shi_ff   <= WMAX;
         slo_ff   <= '0;
         ils_ff   <= 1'b0;
         flip_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         stage_ff <= stage_in;
         top_ff   <= top_in;
         bot_ff   <= bot_in;
         mid_ff   <= mid_in;
         shi_ff   <= shi_in;
         slo_ff   <= slo_in;
         ils_ff   <= ils_in;
         flip_ff  <= flip_in;
         cnt_ff   <= cnt_in;
      end
   end

   // The result is the state after this transaction
   assign top_level    = top_in;
   assign bottom_level = bot_in;
   assign mid_level    = mid_in;
   assign stage        = stage_in;
   assign found        = flip_in;
   assign finished     = (stage_in == pwsf_pkg::ST_DONE);

   assign status.stage     = stage_ff;
   assign status.flip_seen = flip_ff;

endmodule

### src/pwsf_out.sv
module pwsf_out #(
   parameter int DATA_W = 29
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [DATA_W-1:0] in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [DATA_W-1:0] out_data
);

   logic              main_v_ff, main_v_in;
   logic              skid_v_ff, skid_v_in;
   logic [DATA_W-1:0] main_d_ff, main_d_in;
   logic [DATA_W-1:0] skid_d_ff, skid_d_in;
   logic              fire;

   // New transactions are taken while the skid stage is free
   assign in_ready = !skid_v_ff;
   assign fire     = in_valid && in_ready;

   always_comb begin
      main_v_in = main_v_ff;
      skid_v_in = skid_v_ff;
      main_d_in = main_d_ff;
      skid_d_in = skid_d_ff;
      if (!main_v_ff || out_ready) begin
         if (skid_v_ff) begin
            main_v_in = 1'b1;
            main_d_in = skid_d_ff;
            skid_v_in = 1'b0;
         end else begin
            main_v_in = fire;
            main_d_in = in_data;
         end
      end else if (fire) begin
         skid_v_in = 1'b1;
         skid_d_in = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         main_v_ff <= main_v_in;
         skid_v_ff <= skid_v_in;
      end
      main_d_ff <= main_d_in;
      skid_d_ff <= skid_d_in;
   end

   assign out_valid = main_v_ff;
   assign out_data  = main_d_ff;

endmodule

### src/pot_window_signal_finder_top.sv
// Pot window signal finder.
// Channels: req_ch carries commands (start, or a sensor sample), rsp_ch returns one
// transaction per request with the three wiper levels, the stage and the found and
// finished flags as they stand after that request. csr_ch writes the four
// configuration registers (sensor target, gap, iteration limit, mid default) and is
// always ready; write it only while no request is in flight.
// A result is registered in the response register (skid register under a stall).
// Throughput: one request per cycle while req_ch.ready is high, set by the single
// pass of next-state logic between finder state and response registers.
// Stalls: a two-entry output stage (response register plus skid register) holds
// results while rsp_ch.ready is low; req_ch.ready drops only once both are full,
// and rises again in the cycle after the receiver takes a response.
// Reset (synchronous, active high): stage idle, top at full scale, bottom at zero,
// mid at the default level, configuration registers at their reset values, and the
// output stage empty. Samples in the idle or done stage return the levels unchanged.
module pot_window_signal_finder_top #(
   parameter int WIPER_BITS  = 8,
   parameter int SAMPLE_BITS = 12
) (
   input  logic       clock,
   input  logic       reset,
   pwsf_req_if.sink   req_ch,
   pwsf_rsp_if.source rsp_ch,
   pwsf_csr_if.sink   csr_ch
);

   localparam int DATA_W = 3 * WIPER_BITS + pwsf_pkg::STAGE_BITS + 2;

   pwsf_pkg::pwsf_cfg_type          cfg;
   pwsf_pkg::pwsf_status_type       status;
   logic                            take;
   logic [WIPER_BITS-1:0]           top_level;
   logic [WIPER_BITS-1:0]           bottom_level;
   logic [WIPER_BITS-1:0]           mid_level;
   logic [pwsf_pkg::STAGE_BITS-1:0] stage;
   logic                            found;
   logic                            finished;
   logic [DATA_W-1:0]               res_data;
   logic [DATA_W-1:0]               out_data;

   pwsf_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   assign take = req_ch.valid && req_ch.ready;

   pwsf_finder #(
      .WIPER_BITS  (WIPER_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_finder (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .command      (req_ch.command),
      .sample       (req_ch.sample),
      .cfg          (cfg),
      .top_level    (top_level),
      .bottom_level (bottom_level),
      .mid_level    (mid_level),
      .stage        (stage),
      .found        (found),
      .finished     (finished),
      .status       (status)
   );

   // Pack the result for the output stage
   assign res_data = {top_level, bottom_level, mid_level, stage, found, finished};

   pwsf_out #(
      .DATA_W (DATA_W)
   ) u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_data   (res_data),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (out_data)
   );

   assign rsp_ch.top_level    = out_data[DATA_W-1 -: WIPER_BITS];
   assign rsp_ch.bottom_level = out_data[DATA_W-WIPER_BITS-1 -: WIPER_BITS];
   assign rsp_ch.mid_level    = out_data[DATA_W-2*WIPER_BITS-1 -: WIPER_BITS];
   assign rsp_ch.stage        = out_data[pwsf_pkg::STAGE_BITS+1:2];
   assign rsp_ch.found        = out_data[1];
   assign rsp_ch.finished     = out_data[0];

   // A start always leaves the finder searching or taking its side
   a_start_stage: assert property (@(posedge clock) disable iff (reset)
      (take && req_ch.command == pwsf_pkg::CMD_START) |=>
      (status.stage == pwsf_pkg::ST_SEARCH || status.stage == pwsf_pkg::ST_SIDE))
      else $error("start did not enter search or take side");

   // Tracking never falls back to an earlier stage on a sample
   a_track_forward: assert property (@(posedge clock) disable iff (reset)
      (take && req_ch.command == pwsf_pkg::CMD_SAMPLE &&
       status.stage == pwsf_pkg::ST_TRACK) |=>
      (status.stage == pwsf_pkg::ST_TRACK || status.stage == pwsf_pkg::ST_DONE))
      else $error("tracking left for an earlier stage");

   // The flip flag is only set while tracking or once done
   a_flip_stage: assert property (@(posedge clock) disable iff (reset)
      status.flip_seen |->
      (status.stage == pwsf_pkg::ST_TRACK || status.stage == pwsf_pkg::ST_DONE))
      else $error("flip flag set outside tracking");

   // The finished flag of a response agrees with its stage
   a_finished: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.finished == (rsp_ch.stage == pwsf_pkg::ST_DONE)))
      else $error("finished flag disagrees with stage");

endmodule
